[hdl/periodic_interval_timer_64_core_assert.svh]
// Assertion macros used by the timer register file (pit64_regs).
`ifndef PERIODIC_INTERVAL_TIMER_64_CORE_ASSERT_SVH
`define PERIODIC_INTERVAL_TIMER_64_CORE_ASSERT_SVH

// Checked on every clock edge out of reset.
`define PIT64_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PIT64_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/pit64_pkg.sv]
// Types and constants of the 64-bit periodic interval timer.
`timescale 1ns / 1ps
package pit64_pkg;

	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	localparam logic [7:0] OFF_CR    = 8'h00;
	localparam logic [7:0] OFF_MR    = 8'h04;
	localparam logic [7:0] OFF_LSBPR = 8'h08;
	localparam logic [7:0] OFF_MSBPR = 8'h0C;
	localparam logic [7:0] OFF_IER   = 8'h10;
	localparam logic [7:0] OFF_IDR   = 8'h14;
	localparam logic [7:0] OFF_IMR   = 8'h18;
	localparam logic [7:0] OFF_ISR   = 8'h1C;
	localparam logic [7:0] OFF_TLSBR = 8'h20;
	localparam logic [7:0] OFF_TMSBR = 8'h24;
	localparam logic [7:0] OFF_WPMR  = 8'hE4;
	localparam logic [7:0] OFF_WPSR  = 8'hE8;

	localparam int MR_CONT_BIT  = 0;
	localparam int MR_SGCLK_BIT = 3;
	localparam int MR_SMOD_BIT  = 4;
	localparam logic [11:0] MR_WMASK = 12'hF19;

	localparam int INT_PERIOD_BIT = 0;
	localparam int INT_OVRE_BIT   = 1;
	localparam int INT_SECE_BIT   = 4;
	localparam logic [4:0] INT_WMASK = 5'h13;

	localparam int WP_EN_BIT     = 0;
	localparam int WP_ITEN_BIT   = 1;
	localparam int WP_CREN_BIT   = 2;
	localparam int WP_FIRSTE_BIT = 4;
	localparam logic [31:0] WP_KEY      = 32'h5049_5400;
	localparam logic [31:0] WP_KEY_MASK = 32'hFFFF_FF00;
	localparam logic [4:0]  WP_ENA_MASK = 5'h17;

	localparam logic [7:0] WPS_VIOL = 8'h01;
	localparam logic [7:0] WPS_SEQ  = 8'h04;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  reg_offset;
		logic [31:0] write_data;
		logic        tick_source;
	} pit64_item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq;
	} pit64_result_t;

endpackage

[hdl/pit64_if.sv]
// Valid/ready channel interfaces for the timer request and response words.
`timescale 1ns / 1ps
interface pit64_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [7:0]  reg_offset;
	logic [31:0] write_data;
	logic        tick_source;

	modport source (output valid, cmd, reg_offset, write_data, tick_source, input ready);
	modport sink (input valid, cmd, reg_offset, write_data, tick_source, output ready);
endinterface

interface pit64_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic        irq;

	modport source (output valid, read_data, irq, input ready);
	modport sink (input valid, read_data, irq, output ready);
endinterface

[hdl/pit64_in_stage.sv]
// Input register stage: captures one request word per cycle while it is empty or its word is taken.
`timescale 1ns / 1ps
module pit64_in_stage import pit64_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	pit64_req_if.sink       req,
	input  logic            take,
	output logic            valid_s1,
	output pit64_item_t     item_s1
);

	logic load;

	assign req.ready = !valid_s1 || take;
	assign load      = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= '{cmd: req.cmd, reg_offset: req.reg_offset,
				write_data: req.write_data, tick_source: req.tick_source};
		end
	end

endmodule

[hdl/pit64_regs.sv]
// Timer register file, prescaler and 64-bit counter; one word per cycle while fire is high.
`timescale 1ns / 1ps
`include "periodic_interval_timer_64_core_assert.svh"
module pit64_regs import pit64_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  pit64_item_t   item,
	output pit64_result_t result
);

	logic [11:0] mode_q, mode_d;
	logic [31:0] per_lo_q, per_lo_d;
	logic [31:0] per_hi_q, per_hi_d;
	logic [4:0]  mask_q, mask_d;
	logic [4:0]  status_q, status_d;
	logic [31:0] latched_q, latched_d;
	logic        run_q, run_d;
	logic [4:0]  wpm_q, wpm_d;
	logic [23:0] wps_q, wps_d;
	logic [63:0] count_q, count_d;
	logic [3:0]  pres_q, pres_d;

	logic [63:0] period;
	logic [63:0] limit;
	logic [63:0] count_inc;
	logic [3:0]  pres_inc;
	logic        prot;
	logic        can_log;
	logic        period_locked;
	logic [31:0] rdata;

	assign period        = {per_hi_q, per_lo_q};
	assign limit         = (period == 64'd0) ? '1 : period;
	assign count_inc     = count_q + 64'd1;
	assign pres_inc      = pres_q + 4'd1;
	assign can_log       = !wpm_q[WP_FIRSTE_BIT] || (wps_q == 24'd0);
	assign period_locked = run_q && !mode_q[MR_SMOD_BIT];

	always_comb begin
		case (item.reg_offset)
			OFF_CR:                      prot = wpm_q[WP_CREN_BIT];
			OFF_IER, OFF_IDR:            prot = wpm_q[WP_ITEN_BIT];
			OFF_MR, OFF_LSBPR, OFF_MSBPR: prot = wpm_q[WP_EN_BIT];
			default:                     prot = 1'b0;
		endcase
	end

	always_comb begin
		mode_d    = mode_q;
		per_lo_d  = per_lo_q;
		per_hi_d  = per_hi_q;
		mask_d    = mask_q;
		status_d  = status_q;
		latched_d = latched_q;
		run_d     = run_q;
		wpm_d     = wpm_q;
		wps_d     = wps_q;
		count_d   = count_q;
		pres_d    = pres_q;
		rdata     = '0;
		case (item.cmd)
			CMD_READ: begin
				case (item.reg_offset)
					OFF_MR:    rdata = {20'd0, mode_q};
					OFF_LSBPR: rdata = per_lo_q;
					OFF_MSBPR: rdata = per_hi_q;
					OFF_IMR:   rdata = {27'd0, mask_q};
					OFF_ISR: begin
						rdata    = {27'd0, status_q};
						status_d = '0;
					end
					OFF_TLSBR: begin
						rdata     = count_q[31:0];
						latched_d = count_q[63:32];
					end
					OFF_TMSBR: rdata = latched_q;
					OFF_WPMR:  rdata = {27'd0, wpm_q};
					OFF_WPSR: begin
						rdata = {8'd0, wps_q};
						wps_d = '0;
					end
					default: rdata = '0;
				endcase
			end
			CMD_WRITE: begin
				if (prot) begin
					if (can_log) wps_d = {8'd0, item.reg_offset, WPS_VIOL};
				end else begin
					case (item.reg_offset)
						OFF_CR: begin
							if (item.write_data[8]) begin
								mode_d    = '0;
								per_lo_d  = '0;
								per_hi_d  = '0;
								mask_d    = '0;
								status_d  = '0;
								latched_d = '0;
								run_d     = 1'b0;
								count_d   = '0;
								pres_d    = '0;
							end else if (item.write_data[0]) begin
								count_d = '0;
								pres_d  = '0;
								run_d   = 1'b1;
							end
						end
						OFF_MR: begin
							if (run_q) begin
								if (can_log) wps_d = {8'd0, item.reg_offset, WPS_SEQ};
								status_d[INT_SECE_BIT] = 1'b1;
							end else begin
								mode_d = item.write_data[11:0] & MR_WMASK;
							end
						end
						OFF_LSBPR: begin
							if (period_locked) begin
								if (can_log) wps_d = {8'd0, item.reg_offset, WPS_SEQ};
								status_d[INT_SECE_BIT] = 1'b1;
							end else begin
								per_lo_d = item.write_data;
								if (run_q) begin
									count_d = '0;
									pres_d  = '0;
								end
							end
						end
						OFF_MSBPR: begin
							if (period_locked) begin
								if (can_log) wps_d = {8'd0, item.reg_offset, WPS_SEQ};
								status_d[INT_SECE_BIT] = 1'b1;
							end else begin
								per_hi_d = item.write_data;
							end
						end
						OFF_IER: mask_d = mask_q | (item.write_data[4:0] & INT_WMASK);
						OFF_IDR: mask_d = mask_q & ~(item.write_data[4:0] & INT_WMASK);
						OFF_WPMR: begin
							if ((item.write_data & WP_KEY_MASK) == WP_KEY)
								wpm_d = item.write_data[4:0] & WP_ENA_MASK;
						end
						default: ;
					endcase
				end
			end
			CMD_TICK: begin
				if (run_q && (item.tick_source == mode_q[MR_SGCLK_BIT])) begin
					if ((pres_inc != 4'd0) && (pres_inc <= mode_q[11:8])) begin
						pres_d = pres_inc;
					end else begin
						pres_d = '0;
						if (count_inc >= limit) begin
							count_d = '0;
							status_d[INT_PERIOD_BIT] = 1'b1;
							if (status_q[INT_PERIOD_BIT]) status_d[INT_OVRE_BIT] = 1'b1;
							if (!mode_q[MR_CONT_BIT]) run_d = 1'b0;
						end else begin
							count_d = count_inc;
						end
					end
				end
			end
			default: ;
		endcase
	end

	assign result = '{read_data: rdata, irq: |(status_d & mask_d)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= '0;
			per_lo_q  <= '0;
			per_hi_q  <= '0;
			mask_q    <= '0;
			status_q  <= '0;
			latched_q <= '0;
			run_q     <= 1'b0;
			wpm_q     <= '0;
			wps_q     <= '0;
			count_q   <= '0;
			pres_q    <= '0;
		end else if (fire) begin
			mode_q    <= mode_d;
			per_lo_q  <= per_lo_d;
			per_hi_q  <= per_hi_d;
			mask_q    <= mask_d;
			status_q  <= status_d;
			latched_q <= latched_d;
			run_q     <= run_d;
			wpm_q     <= wpm_d;
			wps_q     <= wps_d;
			count_q   <= count_d;
			pres_q    <= pres_d;
		end
	end

	// stopped counter is always parked at zero
	`PIT64_ASSERT(a_stop_parked,
		!run_q |-> (count_q == 64'd0 && pres_q == 4'd0),
		"counter not cleared while stopped")
	`PIT64_ASSERT(a_ovre_needs_period,
		status_q[INT_OVRE_BIT] |-> status_q[INT_PERIOD_BIT],
		"OVRE without PERIOD")
	`PIT64_ASSERT(a_isr_clear,
		(fire && item.cmd == CMD_READ && item.reg_offset == OFF_ISR) |=> (status_q == 5'd0),
		"ISR not cleared on read")
	`PIT64_ASSERT(a_unused_bits,
		(mask_q[3:2] == 2'd0) && (status_q[3:2] == 2'd0) && !wpm_q[3],
		"reserved interrupt or protect bit set")

endmodule

[hdl/pit64_out_stage.sv]
// Output register stage: holds one response word until it is taken.
`timescale 1ns / 1ps
module pit64_out_stage import pit64_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  pit64_result_t result,
	output logic          space,
	pit64_rsp_if.source   rsp
);

	logic          valid_s2;
	pit64_result_t result_s2;

	assign space         = !valid_s2 || rsp.ready;
	assign rsp.valid     = valid_s2;
	assign rsp.read_data = result_s2.read_data;
	assign rsp.irq       = result_s2.irq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_s2 <= result;
		end
	end

endmodule

[hdl/periodic_interval_timer_64_core.sv]
// 64-bit periodic interval timer: one register access, clock tick or no-op per
// word, one response word for each. A word is taken every clock cycle unless the
// response register stalls. The word sits in the input register, then the
// register update (64-bit increment and wrap compare) loads the output register.
// Responses keep request order. While the response register is full and stalled,
// one more request is still taken into the input register.
`timescale 1ns / 1ps
module periodic_interval_timer_64_core import pit64_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	pit64_req_if.sink req,
	pit64_rsp_if.source rsp
);

	logic          valid_s1;
	pit64_item_t   item_s1;
	logic          space;
	logic          fire;
	pit64_result_t result;

	assign fire = valid_s1 && space;

	pit64_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.take     (fire),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	pit64_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.result (result)
	);

	pit64_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (fire),
		.result (result),
		.space  (space),
		.rsp    (rsp)
	);

endmodule

[tb/sv/tb_periodic_interval_timer_64_core.sv]
// Self-checking testbench for the 64-bit periodic interval timer core.
`timescale 1ns / 1ps
module tb_periodic_interval_timer_64_core;
	import pit64_pkg::*;

	localparam logic [1:0]  CMD_NOP   = 2'd3;
	localparam logic [31:0] CR_START  = 32'h0000_0001;
	localparam logic [31:0] CR_SWRST  = 32'h0000_0100;
	localparam logic        SRC_PCLK  = 1'b0;
	localparam logic        SRC_GCLK  = 1'b1;
	localparam int          RAND_WORDS = 1500;
	localparam int          HOLD_CYCLES = 80;

	class timer_shadow;
		logic [11:0] mode_bits;
		logic [31:0] period_lo, period_hi, latched_hi;
		logic [4:0]  irq_mask, irq_status, wp_mode;
		logic [23:0] wp_status;
		logic        running;
		logic [63:0] count;
		logic [3:0]  prescale;
		pit64_result_t due_results[$];
		int mismatches;

		function new();
			clear_state();
			wp_mode = '0;
			wp_status = '0;
			mismatches = 0;
		endfunction

		function void clear_state();
			mode_bits = '0;
			period_lo = '0;
			period_hi = '0;
			irq_mask = '0;
			irq_status = '0;
			latched_hi = '0;
			running = 1'b0;
			count = '0;
			prescale = '0;
		endfunction

		function void start_count();
			count = '0;
			prescale = '0;
			running = 1'b1;
		endfunction

		function void log_error(logic [7:0] off, logic [7:0] code);
			if (!wp_mode[WP_FIRSTE_BIT] || wp_status == '0)
				wp_status = {8'h00, off, code};
			if ((code & WPS_SEQ) != 0)
				irq_status[INT_SECE_BIT] = 1'b1;
		endfunction

		function bit guarded(logic [7:0] off);
			int sel;
			sel = -1;
			case (off)
				OFF_CR: sel = WP_CREN_BIT;
				OFF_IER, OFF_IDR: sel = WP_ITEN_BIT;
				OFF_MR, OFF_LSBPR, OFF_MSBPR: sel = WP_EN_BIT;
				default: sel = -1;
			endcase
			if (sel >= 0 && wp_mode[sel]) begin
				log_error(off, WPS_VIOL);
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function logic [31:0] read_reg(logic [7:0] off);
			logic [31:0] v;
			v = '0;
			case (off)
				OFF_MR:    v = {20'd0, mode_bits};
				OFF_LSBPR: v = period_lo;
				OFF_MSBPR: v = period_hi;
				OFF_IMR:   v = {27'd0, irq_mask};
				OFF_ISR: begin
					v = {27'd0, irq_status};
					irq_status = '0;
				end
				OFF_TLSBR: begin
					latched_hi = count[63:32];
					v = count[31:0];
				end
				OFF_TMSBR: v = latched_hi;
				OFF_WPMR:  v = {27'd0, wp_mode};
				OFF_WPSR: begin
					v = {8'd0, wp_status};
					wp_status = '0;
				end
				default: v = '0;
			endcase
			return v;
		endfunction

		function void write_reg(logic [7:0] off, logic [31:0] val);
			if (off != OFF_WPMR && guarded(off))
				return;
			case (off)
				OFF_CR: begin
					if ((val & CR_SWRST) != 0)
						clear_state();
					else if ((val & CR_START) != 0)
						start_count();
				end
				OFF_MR: begin
					if (running)
						log_error(off, WPS_SEQ);
					else
						mode_bits = val[11:0] & MR_WMASK;
				end
				OFF_LSBPR: begin
					if (running && !mode_bits[MR_SMOD_BIT]) begin
						log_error(off, WPS_SEQ);
					end else begin
						period_lo = val;
						if (running)
							start_count();
					end
				end
				OFF_MSBPR: begin
					if (running && !mode_bits[MR_SMOD_BIT])
						log_error(off, WPS_SEQ);
					else
						period_hi = val;
				end
				OFF_IER: irq_mask = irq_mask | (val[4:0] & INT_WMASK);
				OFF_IDR: irq_mask = irq_mask & ~(val[4:0] & INT_WMASK);
				OFF_WPMR: begin
					if ((val & WP_KEY_MASK) == WP_KEY)
						wp_mode = val[4:0] & WP_ENA_MASK;
				end
				default: ;
			endcase
		endfunction

		function void tick(logic src);
			logic [4:0]  div;
			logic [63:0] limit;
			div = {1'b0, mode_bits[11:8]} + 5'd1;
			if (!running || src != mode_bits[MR_SGCLK_BIT])
				return;
			prescale = prescale + 4'd1;
			if ({1'b0, prescale} < div && prescale != 4'd0)
				return;
			prescale = '0;
			count = count + 64'd1;
			limit = {period_hi, period_lo};
			if (limit == '0)
				limit = '1;
			if (count >= limit) begin
				count = '0;
				if (irq_status[INT_PERIOD_BIT])
					irq_status[INT_OVRE_BIT] = 1'b1;
				irq_status[INT_PERIOD_BIT] = 1'b1;
				if (!mode_bits[MR_CONT_BIT])
					running = 1'b0;
			end
		endfunction

		function void note_word(pit64_item_t w);
			pit64_result_t r;
			r.read_data = '0;
			case (w.cmd)
				CMD_READ:  r.read_data = read_reg(w.reg_offset);
				CMD_WRITE: write_reg(w.reg_offset, w.write_data);
				CMD_TICK:  tick(w.tick_source);
				default: ;
			endcase
			r.irq = |(irq_status & irq_mask);
			due_results.push_back(r);
		endfunction

		function void check_word(pit64_result_t got);
			pit64_result_t want;
			if (due_results.size() == 0) begin
				$error("response word with none expected: read_data %08h irq %0b",
					got.read_data, got.irq);
				mismatches++;
				return;
			end
			want = due_results.pop_front();
			if (got.read_data !== want.read_data) begin
				$error("read_data: expected %08h, got %08h", want.read_data, got.read_data);
				mismatches++;
			end
			if (got.irq !== want.irq) begin
				$error("irq: expected %0b, got %0b", want.irq, got.irq);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	pit64_req_if req_ch();
	pit64_rsp_if rsp_ch();
	timer_shadow shadow = new();
	int words_sent = 0;
	int burst_left = 0;

	periodic_interval_timer_64_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			shadow.note_word('{req_ch.cmd, req_ch.reg_offset, req_ch.write_data,
				req_ch.tick_source});
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			shadow.check_word('{rsp_ch.read_data, rsp_ch.irq});
	end

	task automatic send_word(input logic [1:0] cmd, input logic [7:0] off,
			input logic [31:0] data, input logic src);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				req_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.cmd <= cmd;
		req_ch.reg_offset <= off;
		req_ch.write_data <= data;
		req_ch.tick_source <= src;
		do @(posedge clk); while (!req_ch.ready);
		words_sent++;
	endtask

	task automatic wr(input logic [7:0] off, input logic [31:0] data);
		send_word(CMD_WRITE, off, data, 1'($urandom));
	endtask

	task automatic rd(input logic [7:0] off);
		send_word(CMD_READ, off, $urandom, 1'($urandom));
	endtask

	task automatic tick(input logic src);
		send_word(CMD_TICK, 8'($urandom), $urandom, src);
	endtask

	function automatic logic [7:0] pick_reg();
		case ($urandom_range(0, 11))
			0: return OFF_CR;
			1: return OFF_MR;
			2: return OFF_LSBPR;
			3: return OFF_MSBPR;
			4: return OFF_IER;
			5: return OFF_IDR;
			6: return OFF_IMR;
			7: return OFF_ISR;
			8: return OFF_TLSBR;
			9: return OFF_TMSBR;
			10: return OFF_WPMR;
			default: return OFF_WPSR;
		endcase
	endfunction

	task automatic run_directed();
		wr(OFF_WPMR, 32'hFFFF_FFFF);
		wr(OFF_MR, 32'hFFFF_FFFF);
		wr(OFF_LSBPR, 32'hFFFF_FFFF);
		wr(OFF_MSBPR, 32'hFFFF_FFFF);
		rd(OFF_MR);
		rd(OFF_MSBPR);
		wr(OFF_MR, 32'd1 << MR_CONT_BIT);
		wr(OFF_LSBPR, 32'd2);
		wr(OFF_MSBPR, 32'd0);
		wr(OFF_IER, 32'hFFFF_FFFF);
		wr(OFF_CR, CR_START);
		repeat (4) tick(SRC_PCLK);
		tick(SRC_GCLK);
		rd(OFF_TLSBR);
		rd(OFF_ISR);
		// sequence errors while running
		wr(OFF_MR, 32'd0);
		wr(OFF_LSBPR, 32'd5);
		wr(OFF_WPMR, WP_KEY | 32'(WP_ENA_MASK));
		wr(OFF_CR, CR_START);
		wr(OFF_IDR, 32'hFFFF_FFFF);
		rd(OFF_WPSR);
		wr(OFF_WPMR, WP_KEY);
		wr(OFF_CR, CR_SWRST);
		// zero period counts over the full range; then an unmapped read, an ISR write and a NOP word
		wr(OFF_CR, CR_START);
		tick(SRC_PCLK);
		rd(8'h02);
		wr(OFF_ISR, 32'hFFFF_FFFF);
		send_word(CMD_NOP, OFF_MR, 32'hFFFF_FFFF, SRC_GCLK);
	endtask

	task automatic run_sequence();
		logic [31:0] mr;
		logic [3:0]  pres;
		logic        sel;
		int          steps;
		if ($urandom_range(0, 3) != 0)
			wr(OFF_WPMR, WP_KEY | ($urandom & (32'd1 << WP_FIRSTE_BIT)));
		else if ($urandom_range(0, 1) == 0)
			wr(OFF_WPMR, WP_KEY | ($urandom & 32'hFF));
		if ($urandom_range(0, 4) != 0)
			wr(OFF_CR, $urandom | CR_SWRST);
		pres = ($urandom_range(0, 9) == 0) ? 4'hF : 4'($urandom_range(0, 2));
		mr = ($urandom & ~32'h0000_0F00) | {20'd0, pres, 8'd0};
		sel = mr[MR_SGCLK_BIT];
		wr(OFF_MR, mr);
		case ($urandom_range(0, 19))
			0: wr(OFF_LSBPR, 32'd0);
			1, 2: wr(OFF_LSBPR, $urandom);
			default: wr(OFF_LSBPR, $urandom_range(1, 10));
		endcase
		wr(OFF_MSBPR, ($urandom_range(0, 9) == 0) ? $urandom : 32'd0);
		wr(OFF_IER, $urandom);
		wr(OFF_CR, ($urandom & ~CR_SWRST) | CR_START);
		steps = $urandom_range(8, 50);
		repeat (steps) begin
			case ($urandom_range(0, 99)) inside
				[0:69]: tick(($urandom_range(0, 9) == 0) ? ~sel : sel);
				[70:84]: rd(pick_reg());
				[85:89]: wr(($urandom_range(0, 1) == 0) ? OFF_LSBPR : OFF_MSBPR,
					$urandom_range(0, 12));
				[90:93]: wr(($urandom_range(0, 1) == 0) ? OFF_IER : OFF_IDR, $urandom);
				[94:96]: wr(OFF_MR, $urandom);
				default: wr(OFF_CR, ($urandom & ~CR_SWRST) | CR_START);
			endcase
		end
	endtask

	task automatic run_noise();
		logic [7:0] off;
		off = ($urandom_range(0, 1) == 0) ? pick_reg() : 8'($urandom);
		send_word(2'($urandom_range(0, 3)), off, $urandom, 1'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.cmd <= CMD_READ;
		req_ch.reg_offset <= OFF_CR;
		req_ch.write_data <= '0;
		req_ch.tick_source <= SRC_PCLK;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		while (words_sent < RAND_WORDS) begin
			if ($urandom_range(0, 9) < 7)
				run_sequence();
			else
				repeat ($urandom_range(1, 10)) run_noise();
		end
		req_ch.valid <= 1'b0;
		while (shadow.due_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (shadow.mismatches == 0)
			$display("** periodic_interval_timer_64_core: PASSED **");
		else
			$display("** periodic_interval_timer_64_core: FAILED **");
		$finish;
	end

	// response backpressure: changing patterns plus a couple of long holds
	initial begin
		int  cyc;
		int  style;
		int  left;
		logic go;
		cyc = 0;
		style = 0;
		left = 0;
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (left == 0) begin
				style = $urandom_range(0, 3);
				left = $urandom_range(20, 150);
			end
			left--;
			case (style)
				0: go = 1'b1;
				1: go = ($urandom_range(0, 3) != 0);
				2: go = (cyc % 5 != 4);
				default: go = ($urandom_range(0, 1) == 1);
			endcase
			if (cyc == 700 || cyc == 2000) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				cyc += HOLD_CYCLES;
			end else begin
				rsp_ch.ready <= go;
				@(posedge clk);
				cyc++;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("** periodic_interval_timer_64_core: FAILED **");
		$finish;
	end

endmodule

[filelist.f]
+incdir+hdl
hdl/pit64_pkg.sv
hdl/pit64_if.sv
hdl/pit64_in_stage.sv
hdl/pit64_regs.sv
hdl/pit64_out_stage.sv
hdl/periodic_interval_timer_64_core.sv
tb/sv/tb_periodic_interval_timer_64_core.sv
